// ===== hdl/ppr_pkg.sv =====
// Shared constants, codes and types of the pixel predictor residual block.
package ppr_pkg;

  // Geometry and sample limits
  localparam int MAX_WIDTH = 4096;
  localparam int MAX_DEPTH = 16;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = COL_W + 1;
  localparam int ROW_W     = 16;
  localparam int PIX_W     = 16;
  localparam int RES_W     = 18;

  // Configuration register widths
  localparam int MODE_W  = 3;
  localparam int WIDTH_W = 13;
  localparam int DEPTH_W = 5;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd2;

  // Register reset values
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 13'd640;
  localparam logic [DEPTH_W-1:0] DEPTH_RST = 5'd8;

  // Predictor modes
  typedef enum logic [MODE_W-1:0] {
    MODE_MID   = 3'd0,
    MODE_LEFT  = 3'd1,
    MODE_UP    = 3'd2,
    MODE_AVG   = 3'd3,
    MODE_UPLFT = 3'd4,
    MODE_PAETH = 3'd5,
    MODE_GRAD  = 3'd6
  } mode_e;

  // Pixel context handed from the row stage to the prediction stage
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] left;
    logic             first_col;
    logic             first_row;
    logic             last;
  } ctx_t;

endpackage

// ===== hdl/ppr_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
module ppr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write and read in one process so a same-address read returns the old word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/ppr_ctx.sv =====
// Raster position tracking, row buffer access and the input register stage.
module ppr_ctx import ppr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               advance_ok_i,
  input  logic [PIX_W-1:0]   pixel_i,
  input  logic               frame_start_i,
  input  logic [WIDTH_W-1:0] row_width_i,
  output logic               valid_o,
  output ctx_t               ctx_o,
  output logic [PIX_W-1:0]   up_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [PIX_W-1:0] left_q;
  logic             s1_v_q;
  ctx_t             s1_q;

  logic [CNT_W-1:0] w_eff;
  logic [COL_W-1:0] x;
  logic [ROW_W-1:0] y;
  logic             last;

  // Clamp the row width into one to MAX_WIDTH
  always_comb begin
    if (row_width_i == '0) begin
      w_eff = CNT_W'(1);
    end else if (int'(row_width_i) > MAX_WIDTH) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(row_width_i);
    end
  end

  // Current position, restarted by a frame start
  assign x    = frame_start_i ? '0 : col_q;
  assign y    = frame_start_i ? '0 : row_q;
  assign last = ({1'b0, x} >= (w_eff - CNT_W'(1)));

  // Next position after this pixel
  always_comb begin
    col_d = x + COL_W'(1);
    row_d = y;
    if (last) begin
      col_d = '0;
      if (y != '1) begin
        row_d = y + ROW_W'(1);
      end
    end
  end

  // Advance position and left neighbor on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
      s1_v_q <= 1'b0;
    end else begin
      if (accept_i) begin
        col_q  <= col_d;
        row_q  <= row_d;
        left_q <= pixel_i;
      end
      if (advance_ok_i || !s1_v_q) begin
        s1_v_q <= accept_i;
      end
    end
  end

  // Capture the pixel context beside the row buffer read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q.pix       <= pixel_i;
      s1_q.left      <= left_q;
      s1_q.first_col <= (x == '0);
      s1_q.first_row <= (y == '0);
      s1_q.last      <= last;
    end
  end

  // Row buffer: read the up pixel and replace it with the current one
  ppr_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_buf (
    .clk_i    (clk_i),
    .wr_en_i  (accept_i),
    .wr_addr_i(x),
    .wr_data_i(pixel_i),
    .rd_en_i  (accept_i),
    .rd_addr_i(x),
    .rd_data_o(up_o)
  );

  assign valid_o = s1_v_q;
  assign ctx_o   = s1_q;

endmodule

// ===== hdl/ppr_pred.sv =====
// Prediction, residual and the output register stage.
module ppr_pred import ppr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  ctx_t                    ctx_i,
  input  logic [PIX_W-1:0]        up_i,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic [DEPTH_W-1:0]      depth_i,
  input  logic                    out_ready_i,
  output logic                    out_free_o,
  output logic                    out_valid_o,
  output logic signed [RES_W-1:0] residual_o,
  output logic signed [RES_W-1:0] prediction_o,
  output logic                    row_end_o
);

  logic [PIX_W-1:0]        up_left_q;
  logic                    out_v_q;
  logic signed [RES_W-1:0] res_q;
  logic signed [RES_W-1:0] pred_q;
  logic                    last_q;

  logic [DEPTH_W-1:0]      d_eff;
  logic signed [RES_W-1:0] mid;
  logic signed [RES_W-1:0] up_rule;
  logic signed [RES_W:0]   sa, sb, sc, pa, pb, pc, t_pa, t_pb, t_pc, grad;
  logic [PIX_W-1:0]        paeth_v;
  logic [PIX_W-1:0]        avg;
  logic [PIX_W:0]          ab_sum;
  logic signed [RES_W-1:0] pred;
  logic                    advance;

  // Mid-level from the clamped sample depth
  always_comb begin
    if (depth_i == '0) begin
      d_eff = DEPTH_W'(1);
    end else if (int'(depth_i) > MAX_DEPTH) begin
      d_eff = DEPTH_W'(MAX_DEPTH);
    end else begin
      d_eff = depth_i;
    end
    mid = RES_W'(1) <<< (d_eff - DEPTH_W'(1));
  end

  // Neighbor arithmetic: a is left, b is up, c is up-left
  always_comb begin
    sa   = $signed({3'b000, ctx_i.left});
    sb   = $signed({3'b000, up_i});
    sc   = $signed({3'b000, up_left_q});
    t_pa = sb - sc;
    t_pb = sa - sc;
    t_pc = sa + sb - sc - sc;
    pa   = (t_pa < 0) ? -t_pa : t_pa;
    pb   = (t_pb < 0) ? -t_pb : t_pb;
    pc   = (t_pc < 0) ? -t_pc : t_pc;
    grad = sa + sb - sc;
    if (pa <= pb && pa <= pc) begin
      paeth_v = ctx_i.left;
    end else if (pb <= pc) begin
      paeth_v = up_i;
    end else begin
      paeth_v = up_left_q;
    end
    ab_sum = {1'b0, ctx_i.left} + {1'b0, up_i};
    avg    = ab_sum[PIX_W:1];
  end

  // Select the prediction for the configured mode
  always_comb begin
    up_rule = ctx_i.first_row ? mid : $signed({2'b00, up_i});
    case (mode_i)
      MODE_LEFT: begin
        pred = ctx_i.first_col ? mid : $signed({2'b00, ctx_i.left});
      end
      MODE_UP: begin
        pred = up_rule;
      end
      MODE_AVG, MODE_UPLFT, MODE_PAETH, MODE_GRAD: begin
        if (ctx_i.first_col || ctx_i.first_row) begin
          pred = up_rule;
        end else if (mode_i == MODE_AVG) begin
          pred = $signed({2'b00, avg});
        end else if (mode_i == MODE_UPLFT) begin
          pred = $signed({2'b00, up_left_q});
        end else if (mode_i == MODE_PAETH) begin
          pred = $signed({2'b00, paeth_v});
        end else if (sa < sb && sb < sc) begin
          pred = $signed({2'b00, paeth_v});
        end else begin
          pred = grad[RES_W-1:0];
        end
      end
      default: begin
        pred = mid;
      end
    endcase
  end

  assign out_free_o = !out_v_q || out_ready_i;
  assign advance    = valid_i && out_free_o;

  // Hold the up-left pixel and the output request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_left_q <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (advance) begin
        up_left_q <= up_i;
      end
      if (out_free_o) begin
        out_v_q <= valid_i;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q  <= $signed({2'b00, ctx_i.pix}) - pred;
      pred_q <= pred;
      last_q <= ctx_i.last;
    end
  end

  assign out_valid_o  = out_v_q;
  assign residual_o   = res_q;
  assign prediction_o = pred_q;
  assign row_end_o    = last_q;

endmodule

// ===== hdl/pixel_predictor_residual_core.sv =====
// Top level of the pixel predictor residual block.
//
// Usage: pixels of one sample plane enter in raster order on the slave stream,
// one per request; tuser marks the first pixel of a plane (restarts row and
// column). Each pixel gives one result request on the master stream carrying
// the residual (pixel minus prediction), the prediction, and tlast when the
// pixel ends its row.
// The predictor mode, row width and sample depth are set through the write
// port; the user must write them only while no pixel is in flight, since
// the block does not enforce this. An accepted pixel passes the row buffer
// read stage, then the prediction and output register, to a valid result.
// Throughput: one pixel per cycle while the receiver does not stall, set by
// the row buffer taking one read and one write per cycle.
// Reset clears position counters, neighbors and both pipeline stages and
// loads the register defaults; the row buffer holds no reset contents and
// is defined row by row as pixels pass.
// When the receiver stalls, the result holds in the output register, one more
// pixel is taken into the input stage, and tready then drops until the
// output drains.
module pixel_predictor_residual_core import ppr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // [15:0] pixel
  input  logic [0:0]           s_axis_tuser,  // [0] frame_start
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // [17:0] residual, [35:18] prediction
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [MODE_W-1:0]       mode_q;
  logic [WIDTH_W-1:0]      width_q;
  logic [DEPTH_W-1:0]      depth_q;

  logic                    accept;
  logic                    s1_valid;
  ctx_t                    s1_ctx;
  logic [PIX_W-1:0]        up;
  logic                    out_free;
  logic signed [RES_W-1:0] residual;
  logic signed [RES_W-1:0] prediction;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_MID;
      width_q <= WIDTH_RST;
      depth_q <= DEPTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:  mode_q  <= cfg_data_i[MODE_W-1:0];
        CFG_WIDTH: width_q <= cfg_data_i[WIDTH_W-1:0];
        CFG_DEPTH: depth_q <= cfg_data_i[DEPTH_W-1:0];
        default:   ;
      endcase
    end
  end

  // Take a request when the input stage is empty or moving on
  assign s_axis_tready = !s1_valid || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ppr_ctx u_ctx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .advance_ok_i (out_free),
    .pixel_i      (s_axis_tdata[PIX_W-1:0]),
    .frame_start_i(s_axis_tuser[0]),
    .row_width_i  (width_q),
    .valid_o      (s1_valid),
    .ctx_o        (s1_ctx),
    .up_o         (up)
  );

  ppr_pred u_pred (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .ctx_i       (s1_ctx),
    .up_i        (up),
    .mode_i      (mode_q),
    .depth_i     (depth_q),
    .out_ready_i (m_axis_tready),
    .out_free_o  (out_free),
    .out_valid_o (m_axis_tvalid),
    .residual_o  (residual),
    .prediction_o(prediction),
    .row_end_o   (m_axis_tlast)
  );

  // Pack the result fields, padded to whole bytes
  assign m_axis_tdata = {4'b0000, prediction, residual};

endmodule

// ===== hdl/ppr_checker.sv =====
// Port-level checks of the pixel predictor residual block, bound to the top.
module ppr_checker import ppr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic [RES_W-1:0] rebuilt;

  // Residual plus prediction gives back an unsigned sample
  assign rebuilt = m_axis_tdata[RES_W-1:0] + m_axis_tdata[2*RES_W-1:RES_W];

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // An accepted pixel shows up as a valid result when the output moves after the accept
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing two cycles after accept");

  // Input backpressure only while the output is full and stalled
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // Residual and prediction are consistent with a 16-bit pixel
  a_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> rebuilt[RES_W-1:PIX_W] == '0)
    else $error("residual and prediction do not rebuild a pixel");

endmodule

bind pixel_predictor_residual_core ppr_checker u_ppr_checker (.*);
